@@ rtl/websocket_frame_decoder_unit_macros.svh @@
// ---------------------------------------------------------------------------
// websocket_frame_decoder_unit_macros.svh
// Assertion macros shared by the WebSocket frame decoder checker.
// ---------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DECODER_UNIT_MACROS_SVH
`define WEBSOCKET_FRAME_DECODER_UNIT_MACROS_SVH

// Property checked outside reset only
`define WSFD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every edge, reset included
`define WSFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/wsfd_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wsfd_pkg
// Shared types and constants of the WebSocket frame decoder.
// ---------------------------------------------------------------------------
package wsfd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 16;
  localparam int unsigned KeyW   = 32;
  localparam int unsigned TdataW = 16;
  localparam int unsigned TuserW = 2;

  // Largest frame length the decoder handles at all
  localparam logic [LenW-1:0] MAX_PAYLOAD   = 16'd16384;
  localparam logic [LenW-1:0] LIMIT_RESET   = 16'd16384;

  // Length codes of the second header byte
  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

  // Parser phases
  localparam logic [2:0] PH_HDR0   = 3'd0;
  localparam logic [2:0] PH_HDR1   = 3'd1;
  localparam logic [2:0] PH_EXT_HI = 3'd2;
  localparam logic [2:0] PH_EXT_LO = 3'd3;
  localparam logic [2:0] PH_MASK   = 3'd4;
  localparam logic [2:0] PH_DATA   = 3'd5;

  // Result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_NO_FIN  = 3'd1;
  localparam logic [2:0] ERR_LEN64   = 3'd2;
  localparam logic [2:0] ERR_MAX     = 3'd3;
  localparam logic [2:0] ERR_LIMIT   = 3'd4;

  typedef struct packed {
    logic [1:0]       kind;
    logic [ByteW-1:0] payload_byte;
    logic [3:0]       frame_opcode;
    logic             last_of_frame;
    logic [2:0]       error_code;
  } wsfd_result_t;

endpackage

@@ rtl/wsfd_in_stage.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wsfd_in_stage
// Input register: holds one raw byte until the parser takes it.
// ---------------------------------------------------------------------------
module wsfd_in_stage
  import wsfd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [ByteW-1:0] byte_i,
  output logic             valid_o,
  output logic [ByteW-1:0] byte_o,
  input  logic             take_i
);

  logic             valid_q;
  logic [ByteW-1:0] byte_q;

  // Free when empty or when the held item leaves this cycle
  assign ready_o = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      byte_q <= byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

@@ rtl/wsfd_parser.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wsfd_parser
// Frame state and per-byte decode: header fields, mask key, payload unmask.
// ---------------------------------------------------------------------------
module wsfd_parser
  import wsfd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LenW-1:0]  cfg_wdata_i,
  input  logic             take_i,
  input  logic [ByteW-1:0] byte_i,
  output logic             res_valid_o,
  output wsfd_result_t     res_o
);

  logic [LenW-1:0]  limit_q;
  logic [2:0]       phase_q, phase_d;
  logic [3:0]       opcode_q, opcode_d;
  logic             fin_q, fin_d;
  logic             mask_q, mask_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [KeyW-1:0]  key_q, key_d;
  logic [LenW-1:0]  idx_q, idx_d;
  logic             halted_q, halted_d;

  logic [LenW-1:0]  idx_inc;
  logic [ByteW-1:0] key_byte;
  logic [4:0]       key_shift;

  assign idx_inc   = idx_q + 16'd1;
  assign key_byte  = key_q[{idx_q[1:0], 3'b000} +: ByteW];
  assign key_shift = {idx_q[1:0], 3'b000};

  // Per-byte next state and result
  always_comb begin
    logic            lk_go;
    logic            hd_go;
    logic            raise;
    logic [2:0]      raise_code;
    logic [LenW-1:0] new_len;

    lk_go      = 1'b0;
    hd_go      = 1'b0;
    raise      = 1'b0;
    raise_code = ERR_NONE;
    new_len    = len_q;

    phase_d  = phase_q;
    opcode_d = opcode_q;
    fin_d    = fin_q;
    mask_d   = mask_q;
    len_d    = len_q;
    key_d    = key_q;
    idx_d    = idx_q;
    halted_d = halted_q;

    res_valid_o        = 1'b0;
    res_o.kind          = KIND_DATA;
    res_o.payload_byte  = '0;
    res_o.frame_opcode  = opcode_q;
    res_o.last_of_frame = 1'b0;
    res_o.error_code    = ERR_NONE;

    if (take_i && !halted_q) begin
      case (phase_q)
        PH_HDR0: begin
          fin_d    = byte_i[7];
          opcode_d = byte_i[3:0];
          phase_d  = PH_HDR1;
        end
        PH_HDR1: begin
          if (!fin_q) begin
            raise      = 1'b1;
            raise_code = ERR_NO_FIN;
          end else begin
            mask_d = byte_i[7];
            if (byte_i[6:0] == LEN_CODE_EXT64) begin
              raise      = 1'b1;
              raise_code = ERR_LEN64;
            end else if (byte_i[6:0] == LEN_CODE_EXT16) begin
              len_d   = '0;
              phase_d = PH_EXT_HI;
            end else begin
              new_len = {{(LenW-7){1'b0}}, byte_i[6:0]};
              len_d   = new_len;
              lk_go   = 1'b1;
            end
          end
        end
        PH_EXT_HI: begin
          len_d   = {byte_i, {ByteW{1'b0}}};
          phase_d = PH_EXT_LO;
        end
        PH_EXT_LO: begin
          new_len = {len_q[LenW-1:ByteW], byte_i};
          len_d   = new_len;
          lk_go   = 1'b1;
        end
        PH_MASK: begin
          key_d = key_q | ({{(KeyW-ByteW){1'b0}}, byte_i} << key_shift);
          idx_d = idx_inc;
          if (idx_inc >= 16'd4) begin
            hd_go = 1'b1;
          end
        end
        PH_DATA: begin
          res_valid_o        = 1'b1;
          res_o.kind         = KIND_DATA;
          res_o.payload_byte = mask_q ? (byte_i ^ key_byte) : byte_i;
          if (idx_inc >= len_q) begin
            res_o.last_of_frame = 1'b1;
            phase_d             = PH_HDR0;
            idx_d               = '0;
          end else begin
            idx_d = idx_inc;
          end
        end
        default: begin
          phase_d = PH_HDR0;
        end
      endcase

      // Length complete: maximum check, then mask key or header end
      if (lk_go) begin
        if (new_len > MAX_PAYLOAD) begin
          raise      = 1'b1;
          raise_code = ERR_MAX;
        end else if (mask_d) begin
          phase_d = PH_MASK;
          idx_d   = '0;
          key_d   = '0;
        end else begin
          hd_go = 1'b1;
        end
      end

      // Header complete: limit check, empty frame or payload
      if (hd_go) begin
        idx_d = '0;
        if (new_len > limit_q) begin
          raise      = 1'b1;
          raise_code = ERR_LIMIT;
        end else if (new_len == '0) begin
          phase_d             = PH_HDR0;
          res_valid_o         = 1'b1;
          res_o.kind          = KIND_EMPTY;
          res_o.last_of_frame = 1'b1;
        end else begin
          phase_d = PH_DATA;
        end
      end

      // Any error stops the parser until reset
      if (raise) begin
        halted_d            = 1'b1;
        res_valid_o         = 1'b1;
        res_o.kind          = KIND_ERROR;
        res_o.payload_byte  = '0;
        res_o.last_of_frame = 1'b0;
        res_o.error_code    = raise_code;
      end
    end
  end

  // Limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // Frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR0;
      opcode_q <= '0;
      fin_q    <= 1'b0;
      mask_q   <= 1'b0;
      len_q    <= '0;
      key_q    <= '0;
      idx_q    <= '0;
      halted_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      fin_q    <= fin_d;
      mask_q   <= mask_d;
      len_q    <= len_d;
      key_q    <= key_d;
      idx_q    <= idx_d;
      halted_q <= halted_d;
    end
  end

endmodule

@@ rtl/wsfd_out_fifo.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wsfd_out_fifo
// Two-entry result buffer; space flag comes from registers only.
// ---------------------------------------------------------------------------
module wsfd_out_fifo
  import wsfd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         wr_en_i,
  input  wsfd_result_t wr_data_i,
  output logic         space_o,
  output logic         valid_o,
  input  logic         ready_i,
  output wsfd_result_t rd_data_o
);

  wsfd_result_t entry_q [2];
  logic         wr_ptr_q;
  logic         rd_ptr_q;
  logic [1:0]   count_q;
  logic         pop;

  assign space_o   = (count_q != 2'd2);
  assign valid_o   = (count_q != 2'd0);
  assign pop       = valid_o && ready_i;
  assign rd_data_o = entry_q[rd_ptr_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (wr_en_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({wr_en_i, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      entry_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

@@ rtl/websocket_frame_decoder_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// websocket_frame_decoder_unit
// Byte-serial WebSocket frame decoder with payload unmasking.
// ---------------------------------------------------------------------------
// Raw frame bytes enter on the s_axis channel, one byte per item. Header
// bytes give no item out; each payload byte leaves on m_axis unmasked,
// with tlast on the final byte of its frame. A zero-length frame gives one
// empty-frame item (tlast set). tuser carries the item kind.
// An error (FIN clear, 64-bit length code, length above the maximum or
// above payload_limit) gives one error item, after which every byte is
// dropped until reset. payload_limit is written through cfg_we_i and
// cfg_wdata_i; the user must write it only while the block is idle, as
// the block itself does not enforce this. The input register captures
// a byte when it is accepted; the parser then decodes it and writes its
// result into the result buffer, which offers it on m_axis. Throughput:
// one byte per cycle while the result buffer has room.
// The two-entry result buffer keeps input ready free of any path from
// m_axis_tready_i; when the receiver stalls, input stops once the buffer
// and input register are full, and nothing is lost.
// Reset clears all frame state, empties the buffer and sets
// payload_limit to 16384.
// ---------------------------------------------------------------------------
module websocket_frame_decoder_unit
  import wsfd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_we_i,
  input  logic [LenW-1:0]   cfg_wdata_i,     // payload_limit
  // byte stream in
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [ByteW-1:0]  s_axis_tdata_i,  // [7:0] data_byte
  // results out
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [TdataW-1:0] m_axis_tdata_o,  // [7:0] payload_byte, [11:8] frame_opcode,
                                             // [14:12] error_code, [15] zero
  output logic [TuserW-1:0] m_axis_tuser_o,  // [1:0] kind
  output logic              m_axis_tlast_o   // last_of_frame
);

  logic             in_valid;
  logic [ByteW-1:0] in_byte;
  logic             take;
  logic             space;
  logic             res_valid;
  wsfd_result_t     res;
  wsfd_result_t     out_res;

  // Parser steps whenever a byte is held and the buffer has room
  assign take = in_valid && space;

  wsfd_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .byte_i  (s_axis_tdata_i),
    .valid_o (in_valid),
    .byte_o  (in_byte),
    .take_i  (take)
  );

  wsfd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .take_i      (take),
    .byte_i      (in_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  wsfd_out_fifo u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (res_valid),
    .wr_data_i (res),
    .space_o   (space),
    .valid_o   (m_axis_tvalid_o),
    .ready_i   (m_axis_tready_i),
    .rd_data_o (out_res)
  );

  // Output packing
  assign m_axis_tdata_o = {1'b0, out_res.error_code, out_res.frame_opcode,
                           out_res.payload_byte};
  assign m_axis_tuser_o = out_res.kind;
  assign m_axis_tlast_o = out_res.last_of_frame;

endmodule

@@ rtl/wsfd_checker.sv @@
`timescale 1ns / 1ps
`include "websocket_frame_decoder_unit_macros.svh"
// ---------------------------------------------------------------------------
// wsfd_checker
// Port-level checks on the WebSocket frame decoder result channel.
// ---------------------------------------------------------------------------
module wsfd_checker
  import wsfd_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              m_axis_tvalid_o,
  input logic              m_axis_tready_i,
  input logic [TdataW-1:0] m_axis_tdata_o,
  input logic [TuserW-1:0] m_axis_tuser_o,
  input logic              m_axis_tlast_o
);

  // A stalled item stays put
  `WSFD_ASSERT(a_hold_on_stall, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o), "result changed while stalled")

  // Error code set exactly on error items
  `WSFD_ASSERT(a_err_code_kind, clk_i, rst_ni, m_axis_tvalid_o |-> ((m_axis_tuser_o == KIND_ERROR) == (m_axis_tdata_o[14:12] != ERR_NONE)), "error code does not match kind")

  // Error items never close a frame; empty frames always do
  `WSFD_ASSERT(a_last_by_kind, clk_i, rst_ni, m_axis_tvalid_o |-> ((m_axis_tuser_o != KIND_ERROR) || !m_axis_tlast_o) && ((m_axis_tuser_o != KIND_EMPTY) || m_axis_tlast_o), "tlast wrong for kind")

  // Only payload items carry a data byte
  `WSFD_ASSERT(a_byte_zero, clk_i, rst_ni, m_axis_tvalid_o && (m_axis_tuser_o != KIND_DATA) |-> (m_axis_tdata_o[7:0] == '0), "nonzero byte on non-payload item")

  // Nothing is offered right after reset
  `WSFD_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !m_axis_tvalid_o, "result valid after reset")

endmodule

bind websocket_frame_decoder_unit wsfd_checker u_wsfd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
